// ----- src/sorted_key_set_unit_assert.svh -----
// assertion helpers for the sorted key set unit
// both expect clk and arst_n in scope where they are used
`ifndef SORTED_KEY_SET_UNIT_ASSERT_SVH
`define SORTED_KEY_SET_UNIT_ASSERT_SVH

// condition and consequence in the same cycle
`define SKS_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence in the cycle after the condition
`define SKS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/sks_pkg.sv -----
package sks_pkg;

	// fixed field widths of the request and response beats
	localparam int KEY_W = 32;
	localparam int OP_W  = 2;
	localparam int ST_W  = 2;

	// operation codes, any other code acts as a search
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

	// response status codes
	localparam logic [ST_W-1:0] ST_APPLIED   = 2'd0;
	localparam logic [ST_W-1:0] ST_NO_CHANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

	// controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_WALK,
		S_DECIDE,
		S_INS_NEW,
		S_INS_LINK,
		S_UNLINK,
		S_RELINK,
		S_FIX,
		S_READ_LAST,
		S_COPY,
		S_DONE
	} sks_state_t;

	// datapath commands
	typedef enum logic [3:0] {
		CMD_NOP,
		CMD_LOAD,
		CMD_STEP,
		CMD_INS_NEW,
		CMD_INS_LINK,
		CMD_UNLINK,
		CMD_HEAD_CUR,
		CMD_FIX_START,
		CMD_FIX_STEP,
		CMD_READ_LAST,
		CMD_COPY,
		CMD_FINISH
	} sks_cmd_t;

	// datapath status seen by the controller
	typedef struct packed {
		logic count_zero;
		logic full;
		logic is_insert;
		logic is_delete;
		logic found;
		logic has_prev;
		logic walk_more;
		logic cur_is_last;
		logic head_is_last;
		logic fix_hit;
		logic out_free;
	} sks_sts_t;

endpackage

// ----- src/sks_req_if.sv -----
interface sks_req_if import sks_pkg::*;;

	logic                    valid;
	logic                    ready;
	logic [OP_W-1:0]         operation;
	logic signed [KEY_W-1:0] key;

	modport source (output valid, output operation, output key, input ready);
	modport sink (input valid, input operation, input key, output ready);

endinterface

// ----- src/sks_rsp_if.sv -----
interface sks_rsp_if import sks_pkg::*; #(
	parameter int CNT_W = 5
);

	logic             valid;
	logic             ready;
	logic             found;
	logic [ST_W-1:0]  status;
	logic [CNT_W-1:0] entry_count;

	modport source (output valid, output found, output status, output entry_count, input ready);
	modport sink (input valid, input found, input status, input entry_count, output ready);

endinterface

// ----- src/sks_ctrl.sv -----
module sks_ctrl import sks_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  sks_sts_t sts,
	output sks_cmd_t cmd
);

	sks_state_t state_q;
	sks_state_t state_next;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_next = state_q;
		cmd        = CMD_NOP;
		in_ready   = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd        = CMD_LOAD;
					state_next = sts.count_zero ? S_DECIDE : S_WALK;
				end
			end
			S_WALK: begin
				cmd = CMD_STEP;
				if (!sts.walk_more) begin
					state_next = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (sts.is_insert) begin
					state_next = (sts.found || sts.full) ? S_DONE : S_INS_NEW;
				end else if (sts.is_delete) begin
					state_next = sts.found ? S_UNLINK : S_DONE;
				end else begin
					state_next = S_DONE;
				end
			end
			S_INS_NEW: begin
				cmd        = CMD_INS_NEW;
				state_next = sts.has_prev ? S_INS_LINK : S_DONE;
			end
			S_INS_LINK: begin
				cmd        = CMD_INS_LINK;
				state_next = S_DONE;
			end
			S_UNLINK: begin
				cmd        = CMD_UNLINK;
				state_next = S_RELINK;
			end
			S_RELINK: begin
				// top slot moves into the freed one unless it was freed itself
				if (sts.cur_is_last) begin
					state_next = S_DONE;
				end else if (sts.head_is_last) begin
					cmd        = CMD_HEAD_CUR;
					state_next = S_READ_LAST;
				end else begin
					cmd        = CMD_FIX_START;
					state_next = S_FIX;
				end
			end
			S_FIX: begin
				cmd = CMD_FIX_STEP;
				if (sts.fix_hit) begin
					state_next = S_READ_LAST;
				end
			end
			S_READ_LAST: begin
				cmd        = CMD_READ_LAST;
				state_next = S_COPY;
			end
			S_COPY: begin
				cmd        = CMD_COPY;
				state_next = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd        = CMD_FINISH;
					state_next = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

endmodule

// ----- src/sks_dpath.sv -----
module sks_dpath import sks_pkg::*; #(
	parameter int CAPACITY = 16,
	parameter int KEY_BITS = 32,
	parameter int IDX_W    = 4,
	parameter int CNT_W    = 5
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sks_cmd_t                cmd,
	output sks_sts_t                sts,
	input  logic [OP_W-1:0]         operation,
	input  logic signed [KEY_W-1:0] key,
	input  logic                    rsp_ready,
	output logic                    rsp_valid,
	output logic                    found,
	output logic [ST_W-1:0]         status,
	output logic [CNT_W-1:0]        entry_count
);

	localparam int TAKE_W = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

	// key and link memories
	logic signed [KEY_BITS-1:0] key_mem [CAPACITY];
	logic [IDX_W-1:0]           link_mem [CAPACITY];
	logic signed [KEY_BITS-1:0] key_rd_q;
	logic [IDX_W-1:0]           link_rd_q;

	// control state
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;

	// per request working registers
	logic [OP_W-1:0]            op_q;
	logic signed [KEY_BITS-1:0] key_q;
	logic [IDX_W-1:0]           cur_q;
	logic [IDX_W-1:0]           prev_q;
	logic                       has_prev_q;
	logic [CNT_W-1:0]           idx_q;
	logic                       found_q;
	logic [IDX_W-1:0]           nxt_q;
	logic [IDX_W-1:0]           p_q;

	// response payload
	logic             found_out_q;
	logic [ST_W-1:0]  status_q;
	logic [CNT_W-1:0] count_out_q;

	logic [TAKE_W-1:0]          key_low;
	logic signed [KEY_BITS-1:0] key_ext;
	logic [IDX_W-1:0]           new_slot;
	logic [IDX_W-1:0]           last_slot;
	logic                       less;
	logic [IDX_W-1:0]           rd_addr;
	logic                       key_we;
	logic [IDX_W-1:0]           key_wa;
	logic signed [KEY_BITS-1:0] key_wd;
	logic                       link_we;
	logic [IDX_W-1:0]           link_wa;
	logic [IDX_W-1:0]           link_wd;
	logic [ST_W-1:0]            fin_status;
	logic [CNT_W-1:0]           fin_count;

	// request key: low bits, sign extended to the stored width
	assign key_low = key[TAKE_W-1:0];
	assign key_ext = KEY_BITS'($signed(key_low));

	assign new_slot  = count_q[IDX_W-1:0];
	assign last_slot = IDX_W'(count_q - CNT_W'(1));
	assign less      = key_rd_q < key_q;

	// status toward the controller
	assign sts.count_zero   = (count_q == '0);
	assign sts.full         = (count_q >= CNT_W'(CAPACITY));
	assign sts.is_insert    = (op_q == OP_INSERT);
	assign sts.is_delete    = (op_q == OP_DELETE);
	assign sts.found        = found_q;
	assign sts.has_prev     = has_prev_q;
	assign sts.walk_more    = less && ((idx_q + CNT_W'(1)) < count_q);
	assign sts.cur_is_last  = (cur_q == last_slot);
	assign sts.head_is_last = (head_q == last_slot);
	assign sts.fix_hit      = (link_rd_q == last_slot);
	assign sts.out_free     = !out_valid_q || rsp_ready;

	// read address
	always_comb begin
		case (cmd)
			CMD_LOAD:      rd_addr = head_q;
			CMD_FIX_START: rd_addr = head_q;
			CMD_STEP:      rd_addr = link_rd_q;
			CMD_FIX_STEP:  rd_addr = link_rd_q;
			CMD_READ_LAST: rd_addr = last_slot;
			default:       rd_addr = cur_q;
		endcase
	end

	// memory writes
	always_comb begin
		key_we  = 1'b0;
		key_wa  = cur_q;
		key_wd  = key_q;
		link_we = 1'b0;
		link_wa = cur_q;
		link_wd = cur_q;
		case (cmd)
			CMD_INS_NEW: begin
				key_we  = 1'b1;
				key_wa  = new_slot;
				link_we = 1'b1;
				link_wa = new_slot;
				link_wd = has_prev_q ? cur_q : head_q;
			end
			CMD_INS_LINK: begin
				link_we = 1'b1;
				link_wa = prev_q;
				link_wd = new_slot;
			end
			CMD_UNLINK: begin
				link_we = has_prev_q;
				link_wa = prev_q;
				link_wd = nxt_q;
			end
			CMD_FIX_STEP: begin
				link_we = sts.fix_hit;
				link_wa = p_q;
				link_wd = cur_q;
			end
			CMD_COPY: begin
				key_we  = 1'b1;
				key_wd  = key_rd_q;
				link_we = 1'b1;
				link_wd = link_rd_q;
			end
			default: begin
			end
		endcase
	end

	// memory ports, read data registered
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_wa] <= key_wd;
		end
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		key_rd_q  <= key_mem[rd_addr];
		link_rd_q <= link_mem[rd_addr];
	end

	// result of the request
	always_comb begin
		fin_count  = count_q;
		fin_status = found_q ? ST_APPLIED : ST_NO_CHANGE;
		if (op_q == OP_INSERT) begin
			if (found_q) begin
				fin_status = ST_NO_CHANGE;
			end else if (sts.full) begin
				fin_status = ST_FULL;
			end else begin
				fin_status = ST_APPLIED;
				fin_count  = count_q + CNT_W'(1);
			end
		end else if (op_q == OP_DELETE) begin
			if (found_q) begin
				fin_count = count_q - CNT_W'(1);
			end
		end
	end

	// head, count and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (cmd)
				CMD_INS_NEW: begin
					if (!has_prev_q) begin
						head_q <= new_slot;
					end
				end
				CMD_UNLINK: begin
					if (!has_prev_q) begin
						head_q <= nxt_q;
					end
				end
				CMD_HEAD_CUR: begin
					head_q <= cur_q;
				end
				CMD_FINISH: begin
					count_q <= fin_count;
					if (fin_count == '0) begin
						head_q <= '0;
					end
				end
				default: begin
				end
			endcase
			if (cmd == CMD_FINISH) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// walk, fix-up and response payload registers
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD: begin
				op_q       <= operation;
				key_q      <= key_ext;
				cur_q      <= head_q;
				has_prev_q <= 1'b0;
				idx_q      <= '0;
				found_q    <= 1'b0;
			end
			CMD_STEP: begin
				if (less) begin
					prev_q     <= cur_q;
					has_prev_q <= 1'b1;
					cur_q      <= link_rd_q;
					idx_q      <= idx_q + CNT_W'(1);
				end else begin
					found_q <= (key_rd_q == key_q);
					nxt_q   <= link_rd_q;
				end
			end
			CMD_FIX_START: begin
				p_q <= head_q;
			end
			CMD_FIX_STEP: begin
				if (!sts.fix_hit) begin
					p_q <= link_rd_q;
				end
			end
			CMD_FINISH: begin
				found_out_q <= found_q;
				status_q    <= fin_status;
				count_out_q <= fin_count;
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid   = out_valid_q;
	assign found       = found_out_q;
	assign status      = status_q;
	assign entry_count = count_out_q;

endmodule

// ----- src/sorted_key_set_unit.sv -----
// Sorted key set: holds up to CAPACITY distinct signed keys as an ascending linked list in a
// key memory and a link memory, and answers one insert, delete or search request at a time
// with the found flag, a status and the new key count. The walk reads one stored key per
// cycle through the single registered read port of the two memories. A search or a
// rejected request ends once that walk stops; an insert then also writes the new key and
// the links, and a delete that frees a slot other than the top one may add a second walk
// for the predecessor of the top slot, whose key moves down to keep the live slots packed.
// The request side is ready only when no request is in flight; the result sits in an output
// register, so the next request can be taken while that beat waits. Stored contents need
// no clearing after reset: only data from slots below the held count is ever used.
`include "sorted_key_set_unit_assert.svh"

module sorted_key_set_unit import sks_pkg::*; #(
	parameter int CAPACITY = 16,
	parameter int KEY_BITS = 32
) (
	input logic       clk,
	input logic       arst_n,
	sks_req_if.sink   req,
	sks_rsp_if.source rsp
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	sks_cmd_t         cmd;
	sks_sts_t         sts;
	logic [CNT_W-1:0] entry_count;

	// sequencer
	sks_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// memories, walk registers and result register
	sks_dpath #(
		.CAPACITY (CAPACITY),
		.KEY_BITS (KEY_BITS),
		.IDX_W    (IDX_W),
		.CNT_W    (CNT_W)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.operation   (req.operation),
		.key         (req.key),
		.rsp_ready   (rsp.ready),
		.rsp_valid   (rsp.valid),
		.found       (rsp.found),
		.status      (rsp.status),
		.entry_count (entry_count)
	);

	assign rsp.entry_count = entry_count;

	// checks
	`SKS_ASSERT_NEXT(a_one_in_flight, req.valid && req.ready, !req.ready, "request taken while busy")
	`SKS_ASSERT_SAME(a_count_bound, rsp.valid, entry_count <= CNT_W'(CAPACITY), "count over capacity")
	`SKS_ASSERT_SAME(a_full_reject, rsp.valid && (rsp.status == ST_FULL), !rsp.found && (entry_count == CNT_W'(CAPACITY)), "full reject inconsistent")
	`SKS_ASSERT_SAME(a_finish_free, cmd == CMD_FINISH, sts.out_free, "result overwrites a waiting beat")

endmodule

// ----- tb/sorted_key_set_checker.sv -----
module sorted_key_set_checker import sks_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic clk,
	input  logic arst_n,
	sks_req_if   req,
	sks_rsp_if   rsp,
	output int   mismatches,
	output int   outstanding
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef struct packed {
		logic             found;
		logic [ST_W-1:0]  status;
		logic [CNT_W-1:0] entry_count;
	} set_answer_t;

	// shadow copy of the set, kept sorted ascending in slots 0 .. held-1
	logic signed [KEY_W-1:0] set_keys [CAPACITY];
	int                      held;
	set_answer_t             answers [$];

	// one line per mismatch
	task automatic report(input string msg);
		$display("%0t: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// apply one request to the shadow set and return the answer it should produce
	function automatic set_answer_t apply_request(input logic [OP_W-1:0] op,
		input logic signed [KEY_W-1:0] k);
		set_answer_t a;
		int          pos;
		int          i;
		logic        hit;
		pos = 0;
		while (pos < held && set_keys[pos] < k)
			pos++;
		hit = (pos < held) && (set_keys[pos] == k);
		a.found = hit;
		case (op)
			OP_INSERT: begin
				if (hit) begin
					a.status = ST_NO_CHANGE;
				end else if (held >= CAPACITY) begin
					a.status = ST_FULL;
				end else begin
					for (i = held; i > pos; i--)
						set_keys[i] = set_keys[i-1];
					set_keys[pos] = k;
					held++;
					a.status = ST_APPLIED;
				end
			end
			OP_DELETE: begin
				if (!hit) begin
					a.status = ST_NO_CHANGE;
				end else begin
					for (i = pos; i < held - 1; i++)
						set_keys[i] = set_keys[i+1];
					held--;
					a.status = ST_APPLIED;
				end
			end
			// search, and the spare code that behaves as one
			default: begin
				a.status = hit ? ST_APPLIED : ST_NO_CHANGE;
			end
		endcase
		a.entry_count = held[CNT_W-1:0];
		return a;
	endfunction

	// responses are matched before new requests, a result never leaves in its own request's cycle
	always @(posedge clk or negedge arst_n) begin
		set_answer_t want;
		if (!arst_n) begin
			held = 0;
			answers.delete();
			outstanding <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (answers.size() == 0) begin
					report("response beat with no request waiting");
				end else begin
					want = answers.pop_front();
					if (rsp.found !== want.found)
						report($sformatf("found got %0b expected %0b", rsp.found, want.found));
					if (rsp.status !== want.status)
						report($sformatf("status got %0d expected %0d", rsp.status, want.status));
					if (rsp.entry_count !== want.entry_count)
						report($sformatf("entry_count got %0d expected %0d",
							rsp.entry_count, want.entry_count));
				end
			end
			if (req.valid && req.ready)
				answers.push_back(apply_request(req.operation, req.key));
			outstanding <= answers.size();
		end
	end

endmodule

// ----- tb/tb_sorted_key_set_unit.sv -----
module tb_sorted_key_set_unit;
	import sks_pkg::*;

	localparam int CAPACITY       = 16;
	localparam int KEY_BITS       = 32;
	localparam int CNT_W          = $clog2(CAPACITY + 1);
	localparam int RANDOM_ITEMS   = 1425;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 60;

	// unused code, the block treats it as a search
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

	localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
	localparam logic signed [KEY_W-1:0] KEY_MAX = ~KEY_MIN;

	logic clk = 1'b0;
	logic arst_n;
	logic calm;
	int   stall_left;
	int   idle_cycles;
	int   mismatch_count;
	int   answers_waiting;

	sks_req_if                    req_ch ();
	sks_rsp_if #(.CNT_W(CNT_W))   rsp_ch ();

	sorted_key_set_unit #(
		.CAPACITY(CAPACITY),
		.KEY_BITS(KEY_BITS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	sorted_key_set_checker #(
		.CAPACITY(CAPACITY)
	) checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.mismatches  (mismatch_count),
		.outstanding (answers_waiting)
	);

	always #10 clk = ~clk;

	// mostly short gaps, a few long ones
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// response side stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (calm || $urandom_range(0, 99) < 65) begin
			rsp_ch.ready <= 1'b1;
		end else begin
			rsp_ch.ready <= 1'b0;
			stall_left <= idle_len();
		end
	end

	// end the run when no beat moves on either side for too long
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// one request beat, called at a rising edge, returns at the edge that takes it
	task automatic send_request(input logic [OP_W-1:0] op, input logic signed [KEY_W-1:0] k);
		int gap;
		gap = calm ? 0 : idle_len();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.operation <= op;
		req_ch.key <= k;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	initial begin
		logic signed [KEY_W-1:0] pool [$];
		logic [OP_W-1:0]         op;
		logic signed [KEY_W-1:0] k;
		int                      sent;
		int                      phase_len;
		int                      pool_size;
		int                      insert_pct;
		int                      r;

		arst_n <= 1'b0;
		calm <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.operation <= OP_SEARCH;
		req_ch.key <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty set, extremes, duplicate, spare code, head removal
		send_request(OP_SEARCH, 0);
		send_request(OP_DELETE, 5);
		send_request(OP_INSERT, KEY_MIN);
		send_request(OP_INSERT, KEY_MAX);
		send_request(OP_INSERT, KEY_MIN);
		send_request(OP_SPARE, KEY_MAX);
		send_request(OP_SPARE, 7);
		send_request(OP_DELETE, KEY_MIN);

		// fill to capacity with descending keys, each new one lands at the head
		for (int i = 0; i < CAPACITY - 1; i++)
			send_request(OP_INSERT, 300 - 40 * i);
		send_request(OP_INSERT, 12345);
		send_request(OP_DELETE, 20);
		send_request(OP_SEARCH, KEY_MAX);

		// random phases, each with its own small key pool so that keys collide
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			calm <= ($urandom_range(0, 4) == 0);
			phase_len = $urandom_range(30, 120);
			pool_size = $urandom_range(4, 40);
			insert_pct = $urandom_range(25, 85);
			pool.delete();
			repeat (pool_size) begin
				r = $urandom_range(0, 9);
				if (r == 0)
					k = $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
				else if (r < 3)
					k = $signed($urandom_range(0, 40)) - 20;
				else if (r == 3 && pool.size() > 0)
					k = pool[$urandom_range(0, pool.size() - 1)] + ($urandom_range(0, 1) ? 1 : -1);
				else
					k = $urandom;
				pool.push_back(k);
			end
			repeat (phase_len) begin
				r = $urandom_range(0, 99);
				if (r < insert_pct)
					op = OP_INSERT;
				else if (r < 96)
					op = $urandom_range(0, 1) ? OP_DELETE : OP_SEARCH;
				else
					op = OP_SPARE;
				// a few keys from outside the pool
				if ($urandom_range(0, 9) == 0)
					k = $urandom;
				else
					k = pool[$urandom_range(0, pool.size() - 1)];
				send_request(op, k);
				sent++;
			end
		end

		// drain
		req_ch.valid <= 1'b0;
		calm <= 1'b0;
		@(posedge clk);
		while (answers_waiting != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && answers_waiting == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+src
src/sks_pkg.sv
src/sks_req_if.sv
src/sks_rsp_if.sv
src/sks_ctrl.sv
src/sks_dpath.sv
src/sorted_key_set_unit.sv
tb/sorted_key_set_checker.sv
tb/tb_sorted_key_set_unit.sv
